// ===== rtl/qrs_pkg.sv =====
`default_nettype none
package qrs_pkg;

	localparam int unsigned COEFF_W     = 16;
	localparam int unsigned ROOT_OUT_W  = 32;
	localparam int unsigned RAD_W       = 64;
	localparam int unsigned ROOT_W      = RAD_W / 2;
	localparam int unsigned REM_W       = ROOT_W + 2;
	localparam int unsigned SQRT_STAGES = ROOT_W;
	localparam int unsigned NUM_W       = 35;
	localparam int unsigned DEN_W       = COEFF_W + 1;
	localparam int unsigned DIV_W       = NUM_W + 1;
	localparam int unsigned DIV_STAGES  = DIV_W;

	localparam logic [1:0] COUNT_NONE = 2'd0;
	localparam logic [1:0] COUNT_ONE  = 2'd1;
	localparam logic [1:0] COUNT_TWO  = 2'd2;
	localparam logic [1:0] COUNT_INF  = 2'd3;

	localparam logic signed [ROOT_OUT_W-1:0] Q16_MAX = 32'sh7fff_ffff;
	localparam logic signed [ROOT_OUT_W-1:0] Q16_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_DOUBLE = 3'd1,
		KIND_TWO    = 3'd2,
		KIND_LIN    = 3'd3,
		KIND_INF    = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [COEFF_W-1:0] a;
		logic signed [COEFF_W-1:0] b;
		logic signed [COEFF_W-1:0] c;
	} meta_t;

	typedef struct packed {
		kind_t                   kind;
		logic signed [NUM_W-1:0] n1;
		logic signed [NUM_W-1:0] n2;
		logic signed [COEFF_W-1:0] d;
	} div_req_t;

	typedef struct packed {
		kind_t             kind;
		logic              neg1;
		logic              neg2;
		logic [DIV_W-1:0]  q1;
		logic [DIV_W-1:0]  q2;
	} div_res_t;

endpackage
`default_nettype wire

// ===== rtl/coeff_if.sv =====
`default_nettype none
interface coeff_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] coeff_a;
	logic signed [15:0] coeff_b;
	logic signed [15:0] coeff_c;

	modport source (output valid, coeff_a, coeff_b, coeff_c, input ready);
	modport sink (input valid, coeff_a, coeff_b, coeff_c, output ready);
endinterface
`default_nettype wire

// ===== rtl/root_if.sv =====
`default_nettype none
interface root_if;
	logic               valid;
	logic               ready;
	logic [1:0]         root_count;
	logic signed [31:0] root_first;
	logic signed [31:0] root_second;
	logic               saturated;

	modport source (output valid, root_count, root_first, root_second, saturated,
		input ready);
	modport sink (input valid, root_count, root_first, root_second, saturated,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
`default_nettype none
// Real roots of a*x^2 + b*x + c = 0, coefficients signed Q8.8, roots signed
// Q16.16 rounded to nearest (ties away from zero), clamped with a flag.
// Input channel "coeffs" carries coeff_a/b/c; output channel "roots" carries
// root_count, root_first, root_second and saturated. A transaction completes
// on a rising edge with valid and ready both high.
// Between input and output transaction lie two stages of products and
// discriminant, 32 stages of integer square root (one result bit each),
// one numerator stage, one divider set-up stage, 36 stages of restoring
// division (one quotient bit each, two lanes sharing the divisor) and the
// output register with rounding clamp.
// Throughput is one transaction per cycle while the output does not stall.
// The whole pipeline advances together: when the output register holds a
// result that the receiver does not take, every stage holds and coeffs.ready
// drops; nothing is lost or repeated. With the output free, ready stays high.
// Asynchronous reset empties the pipeline; roots.valid is low after reset.
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	coeff_if.sink     coeffs,
	root_if.source    roots
);

	logic en;

	// stage 1: products
	logic                  valid_s1;
	logic signed [COEFF_W-1:0] a_s1, b_s1, c_s1;
	logic signed [31:0]    bb_s1;
	logic signed [31:0]    ac_s1;

	// stage 2: discriminant and case
	logic                  valid_s2;
	meta_t                 meta_s2;
	logic [RAD_W-1:0]      rad_s2;
	logic signed [33:0]    disc;
	kind_t                 kind_d;

	logic                  sq_valid;
	logic [ROOT_W-1:0]     sq_root;
	meta_t                 sq_meta;

	// stage 3: numerators
	logic                  valid_s3;
	div_req_t              req_s3;
	div_req_t              req_d;
	logic signed [NUM_W-1:0] nb;

	logic                  dv_valid;
	div_res_t              dv_res;

	// stage 4: output register
	logic                  valid_s4;
	logic [1:0]            count_s4;
	logic signed [ROOT_OUT_W-1:0] r1_s4, r2_s4;
	logic                  sat_s4;

	logic [1:0]            count_d;
	logic signed [ROOT_OUT_W-1:0] r1_d, r2_d;
	logic                  sat1, sat2;
	logic signed [ROOT_OUT_W-1:0] v1, v2;

	assign en           = !valid_s4 || roots.ready;
	assign coeffs.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= coeffs.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= sq_valid;
			valid_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coeffs.coeff_a;
			b_s1  <= coeffs.coeff_b;
			c_s1  <= coeffs.coeff_c;
			bb_s1 <= 32'(coeffs.coeff_b) * 32'(coeffs.coeff_b);
			ac_s1 <= 32'(coeffs.coeff_a) * 32'(coeffs.coeff_c);
		end
	end

	always_comb begin
		disc = {{2{bb_s1[31]}}, bb_s1} - {ac_s1, 2'b00};
		if (a_s1 != '0) begin
			if (disc == '0) begin
				kind_d = KIND_DOUBLE;
			end else if (!disc[33]) begin
				kind_d = KIND_TWO;
			end else begin
				kind_d = KIND_NONE;
			end
		end else if (b_s1 != '0) begin
			kind_d = KIND_LIN;
		end else if (c_s1 == '0) begin
			kind_d = KIND_INF;
		end else begin
			kind_d = KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2.kind <= kind_d;
			meta_s2.a    <= a_s1;
			meta_s2.b    <= b_s1;
			meta_s2.c    <= c_s1;
			// radicand is disc * 2^30, only needed for two distinct roots
			rad_s2 <= (kind_d == KIND_TWO) ? {1'b0, disc[32:0], 30'b0} : '0;
		end
	end

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.radicand  (rad_s2),
		.in_meta   (meta_s2),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_meta  (sq_meta)
	);

	always_comb begin
		nb = -{{4{sq_meta.b[COEFF_W-1]}}, sq_meta.b, 15'b0};
		req_d.kind = sq_meta.kind;
		case (sq_meta.kind)
			KIND_DOUBLE, KIND_TWO: begin
				req_d.n1 = nb + {3'b000, sq_root};
				req_d.n2 = nb - {3'b000, sq_root};
				req_d.d  = sq_meta.a;
			end
			KIND_LIN: begin
				req_d.n1 = -{{3{sq_meta.c[COEFF_W-1]}}, sq_meta.c, 16'b0};
				req_d.n2 = '0;
				req_d.d  = sq_meta.b;
			end
			default: begin
				req_d.n1 = '0;
				req_d.n2 = '0;
				req_d.d  = COEFF_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s3 <= req_d;
		end
	end

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.req       (req_s3),
		.out_valid (dv_valid),
		.res       (dv_res)
	);

	// clamp to Q16.16; a negative result may reach 2^31 in magnitude
	always_comb begin
		if (dv_res.neg1) begin
			sat1 = (dv_res.q1[DIV_W-1:32] != '0) ||
				(dv_res.q1[31] && (dv_res.q1[30:0] != '0));
			v1   = sat1 ? Q16_MIN : ROOT_OUT_W'(-dv_res.q1[31:0]);
		end else begin
			sat1 = (dv_res.q1[DIV_W-1:31] != '0);
			v1   = sat1 ? Q16_MAX : ROOT_OUT_W'(dv_res.q1[31:0]);
		end
		if (dv_res.neg2) begin
			sat2 = (dv_res.q2[DIV_W-1:32] != '0) ||
				(dv_res.q2[31] && (dv_res.q2[30:0] != '0));
			v2   = sat2 ? Q16_MIN : ROOT_OUT_W'(-dv_res.q2[31:0]);
		end else begin
			sat2 = (dv_res.q2[DIV_W-1:31] != '0);
			v2   = sat2 ? Q16_MAX : ROOT_OUT_W'(dv_res.q2[31:0]);
		end
		case (dv_res.kind)
			KIND_DOUBLE, KIND_LIN: begin
				count_d = COUNT_ONE;
				r1_d    = v1;
				r2_d    = '0;
			end
			KIND_TWO: begin
				count_d = COUNT_TWO;
				r1_d    = v1;
				r2_d    = v2;
			end
			KIND_INF: begin
				count_d = COUNT_INF;
				r1_d    = '0;
				r2_d    = '0;
			end
			default: begin
				count_d = COUNT_NONE;
				r1_d    = '0;
				r2_d    = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s4 <= count_d;
			r1_s4    <= r1_d;
			r2_s4    <= r2_d;
			sat_s4   <= ((count_d == COUNT_ONE) && sat1) ||
				((count_d == COUNT_TWO) && (sat1 || sat2));
		end
	end

	assign roots.valid       = valid_s4;
	assign roots.root_count  = count_s4;
	assign roots.root_first  = r1_s4;
	assign roots.root_second = r2_s4;
	assign roots.saturated   = sat_s4;

	a_second_only_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && (roots.root_count != COUNT_TWO) |-> roots.root_second == '0)
		else $error("second root set without two roots");

	a_no_root_clean: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && (roots.root_count == COUNT_NONE || roots.root_count == COUNT_INF)
		|-> (roots.root_first == '0) && !roots.saturated)
		else $error("root or flag set with no returned root");

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && roots.saturated |->
		(roots.root_first == Q16_MAX) || (roots.root_first == Q16_MIN) ||
		(roots.root_second == Q16_MAX) || (roots.root_second == Q16_MIN))
		else $error("saturation flag without a clamped root");

endmodule
`default_nettype wire

// ===== rtl/qrs_sqrt.sv =====
`default_nettype none
module qrs_sqrt
	import qrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [RAD_W-1:0]  radicand,
	input  wire meta_t             in_meta,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      root,
	output meta_t                  out_meta
);

	typedef struct packed {
		logic [RAD_W-1:0]  x;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		meta_t             meta;
	} sq_stage_t;

	sq_stage_t                st_s    [SQRT_STAGES];
	logic [SQRT_STAGES-1:0]   valid_s;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
		sq_stage_t         prv;
		sq_stage_t         nxt;
		logic              prv_valid;
		logic [REM_W+1:0]  rs;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			assign prv.x    = radicand;
			assign prv.rem  = '0;
			assign prv.root = '0;
			assign prv.meta = in_meta;
			assign prv_valid = in_valid;
		end else begin : g_next
			assign prv       = st_s[i-1];
			assign prv_valid = valid_s[i-1];
		end

		// one result bit a stage: bring down two radicand bits, try (root<<2)|1
		always_comb begin
			rs    = {prv.rem, prv.x[RAD_W-1 -: 2]};
			trial = {2'b00, prv.root, 2'b01};
			nxt   = prv;
			nxt.x = {prv.x[RAD_W-3:0], 2'b00};
			if (rs >= trial) begin
				nxt.rem  = REM_W'(rs - trial);
				nxt.root = {prv.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rs[REM_W-1:0];
				nxt.root = {prv.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[SQRT_STAGES-1];
	assign root      = st_s[SQRT_STAGES-1].root;
	assign out_meta  = st_s[SQRT_STAGES-1].meta;

endmodule
`default_nettype wire

// ===== rtl/qrs_div.sv =====
`default_nettype none
module qrs_div
	import qrs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire div_req_t  req,
	output logic           out_valid,
	output div_res_t       res
);

	typedef struct packed {
		kind_t             kind;
		logic              neg1;
		logic              neg2;
		logic [DEN_W-1:0]  den;
		logic [DIV_W-1:0]  n1;
		logic [DIV_W-1:0]  n2;
		logic [DEN_W-1:0]  rem1;
		logic [DEN_W-1:0]  rem2;
		logic [DIV_W-1:0]  q1;
		logic [DIV_W-1:0]  q2;
	} dv_stage_t;

	dv_stage_t             pre_s;
	logic                  pre_valid_s;
	dv_stage_t             st_s    [DIV_STAGES];
	logic [DIV_STAGES-1:0] valid_s;

	logic [NUM_W-1:0]   un1;
	logic [NUM_W-1:0]   un2;
	logic [COEFF_W-1:0] ud;
	dv_stage_t          pre_d;

	// rounded quotient as floor((2|n| + |d|) / (2|d|))
	always_comb begin
		un1 = req.n1[NUM_W-1] ? NUM_W'(-req.n1) : NUM_W'(req.n1);
		un2 = req.n2[NUM_W-1] ? NUM_W'(-req.n2) : NUM_W'(req.n2);
		ud  = req.d[COEFF_W-1] ? COEFF_W'(-req.d) : COEFF_W'(req.d);
		pre_d      = '0;
		pre_d.kind = req.kind;
		pre_d.neg1 = req.n1[NUM_W-1] ^ req.d[COEFF_W-1];
		pre_d.neg2 = req.n2[NUM_W-1] ^ req.d[COEFF_W-1];
		pre_d.den  = {ud, 1'b0};
		pre_d.n1   = {un1, 1'b0} + DIV_W'(ud);
		pre_d.n2   = {un2, 1'b0} + DIV_W'(ud);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_s <= 1'b0;
		end else if (en) begin
			pre_valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s <= pre_d;
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
		dv_stage_t        prv;
		dv_stage_t        nxt;
		logic             prv_valid;
		logic [DEN_W:0]   rs1;
		logic [DEN_W:0]   rs2;

		if (i == 0) begin : g_first
			assign prv       = pre_s;
			assign prv_valid = pre_valid_s;
		end else begin : g_next
			assign prv       = st_s[i-1];
			assign prv_valid = valid_s[i-1];
		end

		always_comb begin
			rs1    = {prv.rem1, prv.n1[DIV_W-1]};
			rs2    = {prv.rem2, prv.n2[DIV_W-1]};
			nxt    = prv;
			nxt.n1 = {prv.n1[DIV_W-2:0], 1'b0};
			nxt.n2 = {prv.n2[DIV_W-2:0], 1'b0};
			if (rs1 >= {1'b0, prv.den}) begin
				nxt.rem1 = DEN_W'(rs1 - {1'b0, prv.den});
				nxt.q1   = {prv.q1[DIV_W-2:0], 1'b1};
			end else begin
				nxt.rem1 = rs1[DEN_W-1:0];
				nxt.q1   = {prv.q1[DIV_W-2:0], 1'b0};
			end
			if (rs2 >= {1'b0, prv.den}) begin
				nxt.rem2 = DEN_W'(rs2 - {1'b0, prv.den});
				nxt.q2   = {prv.q2[DIV_W-2:0], 1'b1};
			end else begin
				nxt.rem2 = rs2[DEN_W-1:0];
				nxt.q2   = {prv.q2[DIV_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign res.kind  = st_s[DIV_STAGES-1].kind;
	assign res.neg1  = st_s[DIV_STAGES-1].neg1;
	assign res.neg2  = st_s[DIV_STAGES-1].neg2;
	assign res.q1    = st_s[DIV_STAGES-1].q1;
	assign res.q2    = st_s[DIV_STAGES-1].q2;

endmodule
`default_nettype wire

// ===== tb/sv/tb_quadratic_root_solver.sv =====
`default_nettype none
module tb_quadratic_root_solver;
	import qrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 4000;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
	} coeff_set_t;

	typedef struct packed {
		logic [1:0]         count;
		logic signed [31:0] first;
		logic signed [31:0] second;
		logic               sat;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	coeff_if coeffs();
	root_if roots();

	quadratic_root_solver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.coeffs(coeffs.sink),
		.roots(roots.source)
	);

	always #6 clk = ~clk;

	coeff_set_t pending_sets[$];
	solution_t  expected_solutions[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	bit stimulus_done = 1'b0;

	// n/d rounded to nearest, ties away from zero, clamped to Q16.16
	function automatic logic signed [31:0] rounded_quotient(longint n, longint d,
			inout logic sat);
		bit neg;
		longint un, ud, q;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (2 * un + ud) / (2 * ud);
		if (q == 0)
			return 32'sd0;
		if (neg) begin
			if (q > 64'sd2147483648) begin
				sat = 1'b1;
				return Q16_MIN;
			end
			return 32'(-q);
		end
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return Q16_MAX;
		end
		return 32'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic solution_t solve_roots(coeff_set_t cs);
		solution_t s;
		longint a, b, c, disc, sq;
		a = cs.a;
		b = cs.b;
		c = cs.c;
		s = '0;
		if (a != 0) begin
			disc = b * b - 4 * a * c;
			if (disc == 0) begin
				s.first = rounded_quotient(-b * 32768, a, s.sat);
				s.count = COUNT_ONE;
			end else if (disc > 0) begin
				sq = int_sqrt(longint'(disc) << 30);
				s.first = rounded_quotient(-b * 32768 + sq, a, s.sat);
				s.second = rounded_quotient(-b * 32768 - sq, a, s.sat);
				s.count = COUNT_TWO;
			end else begin
				s.count = COUNT_NONE;
			end
		end else if (b != 0) begin
			s.first = rounded_quotient(-c * 65536, b, s.sat);
			s.count = COUNT_ONE;
		end else begin
			s.count = (c == 0) ? COUNT_INF : COUNT_NONE;
		end
		return s;
	endfunction

	function automatic logic signed [15:0] random_coeff();
		case ($urandom_range(0, 7))
			0: return 16'sd0;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2, 3: return $signed(16'($urandom_range(0, 1023)) - 16'sd512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_set(int a, int b, int c);
		coeff_set_t cs;
		cs.a = 16'(a);
		cs.b = 16'(b);
		cs.c = 16'(c);
		pending_sets.push_back(cs);
	endtask

	initial begin
		coeff_set_t cs;
		int r;
		push_set(256, -768, 512);       // two roots, 1 and 2
		push_set(256, -512, 256);       // double root
		push_set(256, 0, 256);          // negative discriminant
		push_set(0, 512, -256);         // linear
		push_set(0, 0, 256);            // linear, no root
		push_set(0, 0, 0);              // infinitely many
		push_set(1, 32767, 0);          // extreme coefficients, some saturating
		push_set(1, -32768, 0);
		push_set(-32768, 32767, 32767);
		push_set(32767, -32768, -32768);
		push_set(-32768, -32768, -32768);
		push_set(32767, 32767, 32767);
		push_set(0, 1, 32767);
		push_set(0, 1, -32768);
		push_set(0, -32768, 32767);
		push_set(-1, 0, 1);
		push_set(1, 0, -1);
		push_set(3, 1, 0);              // rounding of an inexact root
		push_set(-256, 256, 0);
		for (int i = 0; i < 450; i++) begin
			r = $urandom_range(0, 9);
			cs.a = random_coeff();
			cs.b = random_coeff();
			cs.c = random_coeff();
			if (r == 0) begin
				cs.a = 0;
			end else if (r == 1) begin
				// perfect-square form: b^2 = 4ac with small integers
				cs.a = $signed(16'($urandom_range(1, 40)));
				cs.c = cs.a;
				cs.b = $urandom_range(0, 1) ? 16'(2 * cs.a) : 16'(-2 * cs.a);
			end
			pending_sets.push_back(cs);
		end
		stimulus_done = 1'b1;
	end

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_phase = 0;
	int unsigned stall_mode = 0;
	bit in_accepted = 1'b0;
	bit out_accepted = 1'b0;
	coeff_set_t drive_set;
	coeff_set_t seen_set;
	solution_t  actual;
	solution_t  wanted;

	initial begin
		coeffs.valid = 1'b0;
		coeffs.coeff_a = '0;
		coeffs.coeff_b = '0;
		coeffs.coeff_c = '0;
		roots.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!coeffs.valid || in_accepted) begin
				coeffs.valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_sets.size() > 0) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 16);
					drive_set = pending_sets.pop_front();
					coeffs.coeff_a = drive_set.a;
					coeffs.coeff_b = drive_set.b;
					coeffs.coeff_c = drive_set.c;
					coeffs.valid = 1'b1;
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(0, 5);
				end
			end

			// receiver stalls follow a pattern that changes now and then
			stall_phase++;
			if (stall_phase % 50 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: roots.ready = 1'b1;
				1: roots.ready = (stall_phase % 3) != 0;
				2: roots.ready = (stall_phase % 16) >= 6;
				default: roots.ready = 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_accepted = coeffs.valid && coeffs.ready;
			out_accepted = roots.valid && roots.ready;
			if (in_accepted) begin
				seen_set.a = coeffs.coeff_a;
				seen_set.b = coeffs.coeff_b;
				seen_set.c = coeffs.coeff_c;
				expected_solutions.push_back(solve_roots(seen_set));
			end
			if (out_accepted) begin
				actual.count = roots.root_count;
				actual.first = roots.root_first;
				actual.second = roots.root_second;
				actual.sat = roots.saturated;
				if (expected_solutions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: count %0d first %0d second %0d sat %0b",
							actual.count, actual.first, actual.second, actual.sat);
				end else begin
					wanted = expected_solutions.pop_front();
					if (actual !== wanted) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
								wanted.count, wanted.first, wanted.second, wanted.sat,
								actual.count, actual.first, actual.second, actual.sat);
					end
				end
			end
			if (in_accepted || out_accepted)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
			if (stimulus_done && pending_sets.size() == 0 && !coeffs.valid &&
					expected_solutions.size() == 0) begin
				if (mismatches == 0)
					$display("SUCCESS");
				else
					$display("FAILURE");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
